// ----- hdl/zero_page_run_scanner_macros.svh -----
// Assertion macros shared by the zero page run scanner.
// Included by the top level; needs nothing else.
`ifndef ZERO_PAGE_RUN_SCANNER_MACROS_SVH
`define ZERO_PAGE_RUN_SCANNER_MACROS_SVH

// same-cycle implication, reset masked
`define ZPRS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define ZPRS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/zprs_pkg.sv -----
// Types and constants of the zero page run scanner.
// No dependencies.
package zprs_pkg;

  localparam int ADDR_W   = 64;
  localparam int WORD_W   = 64;
  localparam int PAGES_W  = 52;
  localparam int PW_W     = 13;
  localparam int PW_RESET = 512;

  localparam logic [PAGES_W-1:0] RUN_MAX = '1;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [PAGES_W-1:0] pages;
  } run_t;

endpackage

// ----- hdl/zprs_ifs.sv -----
// Stream interfaces of the zero page run scanner: memory words in, runs out.
// Depends on zprs_pkg.
interface zprs_word_if;
  logic                        valid;
  logic                        ready;
  logic                        range_first;
  logic                        range_last;
  logic [zprs_pkg::ADDR_W-1:0] page_address;
  logic [zprs_pkg::WORD_W-1:0] word;

  modport source (output valid, range_first, range_last, page_address, word, input ready);
  modport sink   (input valid, range_first, range_last, page_address, word, output ready);
endinterface

interface zprs_run_if;
  logic                         valid;
  logic                         ready;
  logic [zprs_pkg::ADDR_W-1:0]  run_address;
  logic [zprs_pkg::PAGES_W-1:0] run_pages;

  modport source (output valid, run_address, run_pages, input ready);
  modport sink   (input valid, run_address, run_pages, output ready);
endinterface

// ----- hdl/zero_page_run_scanner.sv -----
// Zero page run scanner top level: core tracker feeding the result buffer.
// Depends on zprs_pkg, zprs_ifs, zprs_core, zprs_out_buf and the macros header.
//
// Takes one 64-bit memory word per cycle while ready is high and reports
// each finished run of all-zero pages as its first page address and page
// count. The page and run state update in a single step for each word, and
// the result of a word that closes a run is held in output registers. A
// two-entry output buffer absorbs a stalled consumer; words keep flowing
// until both entries hold results, then ready drops until one is taken.
// The page size register is clamped to 1..MAX_PAGE_WORDS when written.
`include "zero_page_run_scanner_macros.svh"

module zero_page_run_scanner #(
  parameter int MAX_PAGE_WORDS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [zprs_pkg::PW_W-1:0] cfg_wdata_i,
  zprs_word_if.sink                 words_i,
  zprs_run_if.source                runs_o
);

  logic           accept;
  logic           emit;
  logic           buf_ready;
  zprs_pkg::run_t run;

  assign words_i.ready = buf_ready;
  assign accept        = words_i.valid && buf_ready;

  zprs_core #(
    .MAX_PAGE_WORDS(MAX_PAGE_WORDS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .range_first_i (words_i.range_first),
    .range_last_i  (words_i.range_last),
    .page_address_i(words_i.page_address),
    .word_i        (words_i.word),
    .emit_o        (emit),
    .run_o         (run)
  );

  zprs_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (emit),
    .data_i (run),
    .ready_o(buf_ready),
    .runs_o (runs_o)
  );

  `ZPRS_ASSERT_IMPL(a_full_has_output, clk_i, rst_ni, !buf_ready, runs_o.valid, "full buffer without output")
  `ZPRS_ASSERT_NEXT(a_stall_fills_skid, clk_i, rst_ni, emit && runs_o.valid && !runs_o.ready, !buf_ready, "result lost on stall")
  `ZPRS_ASSERT_IMPL(a_run_nonempty, clk_i, rst_ni, emit, run.pages != '0, "empty run emitted")

endmodule

// ----- hdl/zprs_core.sv -----
// Page and run tracking: updates the scan state once per accepted word.
// Depends on zprs_pkg.
module zprs_core #(
  parameter int MAX_PAGE_WORDS = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [zprs_pkg::PW_W-1:0]   cfg_wdata_i,
  input  logic                        accept_i,
  input  logic                        range_first_i,
  input  logic                        range_last_i,
  input  logic [zprs_pkg::ADDR_W-1:0] page_address_i,
  input  logic [zprs_pkg::WORD_W-1:0] word_i,
  output logic                        emit_o,
  output zprs_pkg::run_t              run_o
);

  localparam int IXW = $clog2(MAX_PAGE_WORDS);
  localparam int IW  = $clog2(MAX_PAGE_WORDS + 1);
  localparam int CW  = (IW > zprs_pkg::PW_W) ? IW : zprs_pkg::PW_W;
  localparam int EFF_RESET =
    (zprs_pkg::PW_RESET > MAX_PAGE_WORDS) ? MAX_PAGE_WORDS : zprs_pkg::PW_RESET;

  logic [IW-1:0]                eff_q, eff_d;
  logic [IXW-1:0]               idx_q, idx_d;
  logic                         az_q, az_d;
  logic [zprs_pkg::ADDR_W-1:0]  cur_q, cur_d;
  logic [zprs_pkg::ADDR_W-1:0]  rs_q, rs_d;
  logic [zprs_pkg::PAGES_W-1:0] rl_q, rl_d;

  logic [CW-1:0] pw_ext;

  // clamp the page size once, at the write
  always_comb begin
    pw_ext = CW'(cfg_wdata_i);
    if (pw_ext == '0) begin
      eff_d = IW'(1);
    end else if (pw_ext > CW'(MAX_PAGE_WORDS)) begin
      eff_d = IW'(MAX_PAGE_WORDS);
    end else begin
      eff_d = pw_ext[IW-1:0];
    end
  end

  logic [IXW-1:0]               idx0;
  logic [IXW:0]                 idx1;
  logic                         az0, az1, page_end;
  logic [zprs_pkg::PAGES_W-1:0] rl0, rl1;
  logic [zprs_pkg::ADDR_W-1:0]  rs1;

  always_comb begin
    idx0  = range_first_i ? '0 : idx_q;
    az0   = range_first_i ? 1'b1 : az_q;
    rl0   = range_first_i ? '0 : rl_q;
    cur_d = (idx0 == '0) ? page_address_i : cur_q;
    az1   = az0 && (word_i == '0);
    idx1  = {1'b0, idx0} + (IXW+1)'(1);
    page_end = idx1 >= (IXW+1)'(eff_q);

    emit_o        = 1'b0;
    run_o.address = rs_q;
    run_o.pages   = rl0;
    rs1   = rs_q;
    rl1   = rl0;
    idx_d = idx1[IXW-1:0];
    az_d  = az1;

    if (page_end) begin
      idx_d = '0;
      az_d  = 1'b1;
      if (az1) begin
        if (rl0 == '0) rs1 = cur_d;
        if (rl0 != zprs_pkg::RUN_MAX) rl1 = rl0 + zprs_pkg::PAGES_W'(1);
      end else if (rl0 != '0) begin
        emit_o = 1'b1;
        rl1    = '0;
      end
    end

    if (range_last_i) begin
      idx_d = '0;
      az_d  = 1'b1;
      if (rl1 != '0) begin
        emit_o        = 1'b1;
        run_o.address = rs1;
        run_o.pages   = rl1;
        rl1           = '0;
      end
    end

    rs_d = rs1;
    rl_d = rl1;
    emit_o = emit_o && accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_q <= IW'(EFF_RESET);
      idx_q <= '0;
      az_q  <= 1'b1;
      rl_q  <= '0;
    end else begin
      if (cfg_we_i) eff_q <= eff_d;
      if (accept_i) begin
        idx_q <= idx_d;
        az_q  <= az_d;
        rl_q  <= rl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cur_q <= cur_d;
      rs_q  <= rs_d;
    end
  end

endmodule

// ----- hdl/zprs_out_buf.sv -----
// Two-entry result buffer: output register plus skid entry.
// Depends on zprs_pkg and zprs_run_if.
module zprs_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  zprs_pkg::run_t data_i,
  output logic           ready_o,
  zprs_run_if.source     runs_o
);

  logic           v0_q, v0_d, v1_q, v1_d;
  zprs_pkg::run_t d0_q, d0_d, d1_q, d1_d;
  logic           pop;

  assign pop     = v0_q && runs_o.ready;
  assign ready_o = !v1_q;

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    d0_d = d0_q;
    d1_d = d1_q;
    if (v1_q) begin
      if (pop) begin
        d0_d = d1_q;
        v1_d = 1'b0;
      end
    end else if (push_i) begin
      if (!v0_q || pop) begin
        d0_d = data_i;
        v0_d = 1'b1;
      end else begin
        d1_d = data_i;
        v1_d = 1'b1;
      end
    end else if (pop) begin
      v0_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d0_q <= d0_d;
    d1_q <= d1_d;
  end

  assign runs_o.valid       = v0_q;
  assign runs_o.run_address = d0_q.address;
  assign runs_o.run_pages   = d0_q.pages;

endmodule
